// ===== hdl/hrc_pkg.sv =====
// Shared types and constants for the handle range coalescer.
// No dependencies; used by the interfaces and every module.
package hrc_pkg;

	localparam int unsigned HANDLE_W     = 16;
	localparam int unsigned CFG_IDX_W    = 4;
	localparam int unsigned STATUS_W     = 2;
	localparam int unsigned HEADER_BYTES = 1;
	localparam int unsigned PAIR_BYTES   = 4;
	localparam int unsigned OUTQ_DEPTH   = 4;
	localparam int unsigned OUTQ_PTR_W   = $clog2(OUTQ_DEPTH);

	localparam logic [HANDLE_W-1:0] RANGE_START_RST = 16'd1;
	localparam logic [HANDLE_W-1:0] RANGE_END_RST   = 16'hFFFF;
	localparam logic [HANDLE_W-1:0] WANTED_TYPE_RST = 16'd0;
	localparam logic [HANDLE_W-1:0] MTU_RST         = 16'd23;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RANGE_START = 4'd0,
		REG_RANGE_END   = 4'd1,
		REG_WANTED_TYPE = 4'd2,
		REG_CHANNEL_MTU = 4'd3
	} cfg_reg_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK            = 2'd0,
		ST_NOT_FOUND     = 2'd1,
		ST_INVALID_RANGE = 2'd2,
		ST_READ_FAIL     = 2'd3
	} scan_status_t;

	typedef struct packed {
		logic [HANDLE_W-1:0] entry_handle;
		logic [HANDLE_W-1:0] entry_type16;
		logic                value_equal;
		logic                value_read_failed;
		logic                last_entry;
	} entry_t;

	typedef struct packed {
		logic                range_valid;
		logic [HANDLE_W-1:0] group_start;
		logic [HANDLE_W-1:0] group_end;
		logic                scan_done;
		logic [STATUS_W-1:0] scan_status;
	} result_t;

	// Results produced by one entry, handed to the output queue.
	typedef struct packed {
		logic [1:0] count;
		result_t    res0;
		result_t    res1;
	} result_wr_t;

endpackage

// ===== hdl/hrc_ifs.sv =====
// Channel interfaces: entry input, result output and configuration write.
// Depends on hrc_pkg for field widths.
interface hrc_entry_if;
	logic                         valid;
	logic                         ready;
	logic [hrc_pkg::HANDLE_W-1:0] entry_handle;
	logic [hrc_pkg::HANDLE_W-1:0] entry_type16;
	logic                         value_equal;
	logic                         value_read_failed;
	logic                         last_entry;

	modport source (output valid, entry_handle, entry_type16, value_equal,
		value_read_failed, last_entry, input ready);
	modport sink (input valid, entry_handle, entry_type16, value_equal,
		value_read_failed, last_entry, output ready);
endinterface

interface hrc_result_if;
	logic                         valid;
	logic                         ready;
	logic                         range_valid;
	logic [hrc_pkg::HANDLE_W-1:0] group_start;
	logic [hrc_pkg::HANDLE_W-1:0] group_end;
	logic                         scan_done;
	logic [hrc_pkg::STATUS_W-1:0] scan_status;

	modport source (output valid, range_valid, group_start, group_end, scan_done,
		scan_status, input ready);
	modport sink (input valid, range_valid, group_start, group_end, scan_done,
		scan_status, output ready);
endinterface

interface hrc_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [hrc_pkg::CFG_IDX_W-1:0] index;
	logic [hrc_pkg::HANDLE_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/hrc_outq.sv =====
// Result queue: takes up to two results per cycle, delivers one per transfer.
// Depends on hrc_pkg and hrc_result_if.
module hrc_outq (
	input  logic                clk,
	input  logic                arst_n,
	input  hrc_pkg::result_wr_t wr,
	output logic                room,
	hrc_result_if.source        result_ch
);
	import hrc_pkg::*;

	result_t               mem_q [OUTQ_DEPTH];
	logic [OUTQ_PTR_W-1:0] wp_q;
	logic [OUTQ_PTR_W-1:0] rp_q;
	logic [OUTQ_PTR_W:0]   cnt_q;
	logic                  pop;
	result_t               head;

	assign room = cnt_q <= (OUTQ_PTR_W+1)'(OUTQ_DEPTH - 2);
	assign pop  = result_ch.valid && result_ch.ready;
	assign head = mem_q[rp_q];

	assign result_ch.valid       = cnt_q != '0;
	assign result_ch.range_valid = head.range_valid;
	assign result_ch.group_start = head.group_start;
	assign result_ch.group_end   = head.group_end;
	assign result_ch.scan_done   = head.scan_done;
	assign result_ch.scan_status = head.scan_status;

	always_ff @(posedge clk) begin
		if (wr.count != 2'd0) begin
			mem_q[wp_q] <= wr.res0;
		end
		if (wr.count == 2'd2) begin
			mem_q[wp_q + OUTQ_PTR_W'(1)] <= wr.res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + OUTQ_PTR_W'(wr.count);
			rp_q  <= rp_q + OUTQ_PTR_W'(pop);
			cnt_q <= cnt_q + (OUTQ_PTR_W+1)'(wr.count) - (OUTQ_PTR_W+1)'(pop);
		end
	end

endmodule

// ===== hdl/hrc_scan.sv =====
// Entry register, configuration registers, run state and the per-entry
// merge logic. Depends on hrc_pkg, hrc_entry_if and hrc_cfg_if.
module hrc_scan (
	input  logic                 clk,
	input  logic                 arst_n,
	hrc_entry_if.sink            entry_ch,
	hrc_cfg_if.sink              cfg_ch,
	input  logic                 room,
	output hrc_pkg::result_wr_t  wr
);
	import hrc_pkg::*;

	localparam logic [HANDLE_W-1:0] HDR = HANDLE_W'(HEADER_BYTES);
	localparam logic [HANDLE_W-1:0] PB  = HANDLE_W'(PAIR_BYTES);

	logic [HANDLE_W-1:0] start_q, end_q, type_q, mtu_q;
	logic [HANDLE_W-1:0] run_first_q, run_prev_q, resp_len_q;
	logic                finished_q;
	logic                v_s1;
	entry_t              item_s1;
	logic                fire;

	logic [HANDLE_W-1:0] rf, rp, rl, h;
	logic [HANDLE_W-1:0] nrf, nrp, nrl;
	logic                nfin;
	logic                open, fit1, fit2, fits_last, ended, match, tmatch;
	logic [1:0]          k;
	result_t             res [2];

	assign fire           = v_s1 && room;
	assign entry_ch.ready = !v_s1 || room;
	assign cfg_ch.ready   = 1'b1;

	always_comb begin
		rf   = finished_q ? '0 : run_first_q;
		rp   = finished_q ? '0 : run_prev_q;
		rl   = finished_q ? HDR : resp_len_q;
		h    = item_s1.entry_handle;
		open = rf != '0;
		fit1 = ({1'b0, rl} + (HANDLE_W+1)'(PAIR_BYTES)) <= {1'b0, mtu_q};
		fit2 = ({2'b0, rl} + (HANDLE_W+2)'(2*PAIR_BYTES)) <= {2'b0, mtu_q};
		tmatch = (h >= start_q) && (item_s1.entry_type16 == type_q);
		match  = tmatch && item_s1.value_equal;
		nrf   = rf;
		nrp   = rp;
		nrl   = rl;
		nfin  = 1'b0;
		k     = 2'd0;
		ended = 1'b0;
		fits_last = 1'b0;
		res[0] = '0;
		res[1] = '0;

		if ((start_q == '0) || (start_q > end_q)) begin
			res[0].scan_done   = 1'b1;
			res[0].scan_status = ST_INVALID_RANGE;
			k    = 2'd1;
			nfin = 1'b1;
		end else if (h > end_q) begin
			if (open && fit1) begin
				res[0].range_valid = 1'b1;
				res[0].group_start = rf;
				res[0].group_end   = rp;
				nrl = rl + PB;
			end
			res[0].scan_done   = 1'b1;
			res[0].scan_status = (nrl > HDR) ? ST_OK : ST_NOT_FOUND;
			k    = 2'd1;
			nfin = 1'b1;
		end else if (tmatch && item_s1.value_read_failed) begin
			res[0].scan_done   = 1'b1;
			res[0].scan_status = ST_READ_FAIL;
			k    = 2'd1;
			nfin = 1'b1;
		end else begin
			if (match) begin
				if (!open) begin
					nrf = h;
					nrp = h;
				end else if ({1'b0, h} == ({1'b0, rp} + 17'd1)) begin
					nrp = h;
				end else if (fit1) begin
					res[0].range_valid = 1'b1;
					res[0].group_start = rf;
					res[0].group_end   = rp;
					k   = 2'd1;
					nrl = rl + PB;
					nrf = h;
					nrp = h;
				end else begin
					ended = 1'b1;
				end
			end else if (open) begin
				if (fit1) begin
					res[0].range_valid = 1'b1;
					res[0].group_start = rf;
					res[0].group_end   = rp;
					k   = 2'd1;
					nrl = rl + PB;
					nrf = '0;
					nrp = '0;
				end else begin
					ended = 1'b1;
				end
			end

			if (ended) begin
				res[0] = '0;
				res[0].scan_done   = 1'b1;
				res[0].scan_status = (rl > HDR) ? ST_OK : ST_NOT_FOUND;
				k    = 2'd1;
				nfin = 1'b1;
			end else if (item_s1.last_entry) begin
				fits_last = (k != 2'd0) ? fit2 : fit1;
				if ((nrf != '0) && fits_last) begin
					res[k[0]].range_valid = 1'b1;
					res[k[0]].group_start = nrf;
					res[k[0]].group_end   = nrp;
					nrl = nrl + PB;
					k   = k + 2'd1;
				end
				if (k == 2'd0) begin
					k = 2'd1;
				end
				res[~k[0]].scan_done   = 1'b1;
				res[~k[0]].scan_status = (nrl > HDR) ? ST_OK : ST_NOT_FOUND;
				nfin = 1'b1;
			end
		end

		wr.count = fire ? k : 2'd0;
		wr.res0  = res[0];
		wr.res1  = res[1];
	end

	always_ff @(posedge clk) begin
		if (entry_ch.valid && entry_ch.ready) begin
			item_s1.entry_handle      <= entry_ch.entry_handle;
			item_s1.entry_type16      <= entry_ch.entry_type16;
			item_s1.value_equal       <= entry_ch.value_equal;
			item_s1.value_read_failed <= entry_ch.value_read_failed;
			item_s1.last_entry        <= entry_ch.last_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			start_q     <= RANGE_START_RST;
			end_q       <= RANGE_END_RST;
			type_q      <= WANTED_TYPE_RST;
			mtu_q       <= MTU_RST;
			run_first_q <= '0;
			run_prev_q  <= '0;
			resp_len_q  <= HDR;
			finished_q  <= 1'b0;
		end else begin
			if (entry_ch.ready) begin
				v_s1 <= entry_ch.valid;
			end
			if (fire) begin
				run_first_q <= nrf;
				run_prev_q  <= nrp;
				resp_len_q  <= nrl;
				finished_q  <= nfin;
			end
			if (cfg_ch.valid) begin
				case (cfg_ch.index)
					REG_RANGE_START: start_q <= cfg_ch.data;
					REG_RANGE_END:   end_q   <= cfg_ch.data;
					REG_WANTED_TYPE: type_q  <= cfg_ch.data;
					REG_CHANNEL_MTU: mtu_q   <= cfg_ch.data;
					default: ;
				endcase
			end
		end
	end

endmodule

// ===== hdl/handle_range_coalescer.sv =====
// Handle range coalescer: merges matching attribute handles into start/end pairs.
// Path: entry register in hrc_scan, then the result queue. Throughput: one entry
// per cycle while the queue has room; an entry that yields two results takes two
// output transfers, and the four-deep result queue sets how far input runs ahead.
// Reset: async active low; registers return to defaults, run state and queue clear.
// Depends on hrc_pkg, hrc_ifs, hrc_scan and hrc_outq.
module handle_range_coalescer (
	input  logic          clk,
	input  logic          arst_n,
	hrc_entry_if.sink     entry_ch,
	hrc_cfg_if.sink       cfg_ch,
	hrc_result_if.source  result_ch
);
	import hrc_pkg::*;

	result_wr_t wr;
	logic       room;

	hrc_scan u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.entry_ch (entry_ch),
		.cfg_ch   (cfg_ch),
		.room     (room),
		.wr       (wr)
	);

	hrc_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (wr),
		.room      (room),
		.result_ch (result_ch)
	);

endmodule

// ===== tb/hrc_checker.sv =====
// Checker for the handle range coalescer: watches the entry, configuration and result
// channels, predicts the results of every entry transfer and compares them in order.
// Depends on hrc_pkg and hrc_ifs.
module hrc_checker (
	input  logic  clk,
	input  logic  arst_n,
	hrc_entry_if  entry_ch,
	hrc_cfg_if    cfg_ch,
	hrc_result_if result_ch,
	output int    fail_count,
	output int    pending_count
);
	import hrc_pkg::*;

	logic [HANDLE_W-1:0] lo_handle, hi_handle, match_type, mtu_bytes;
	logic [HANDLE_W-1:0] open_first, open_last, resp_bytes;
	logic                scan_closed;
	result_t             expected_q[$];
	int                  step_results;
	int                  errors;

	// Close the open run; returns 0 when the pair no longer fits the MTU.
	function automatic bit close_run();
		result_t r;
		if (open_first == '0) return 1'b1;
		if (32'(resp_bytes) + PAIR_BYTES > 32'(mtu_bytes)) return 1'b0;
		r = '0;
		r.range_valid = 1'b1;
		r.group_start = open_first;
		r.group_end   = open_last;
		expected_q.push_back(r);
		step_results++;
		resp_bytes = resp_bytes + 16'(PAIR_BYTES);
		open_first = '0;
		open_last  = '0;
		return 1'b1;
	endfunction

	function automatic void end_scan(scan_status_t st);
		result_t r;
		scan_closed = 1'b1;
		if (step_results > 0) begin
			r = expected_q.pop_back();
		end else begin
			r = '0;
			step_results++;
		end
		r.scan_done   = 1'b1;
		r.scan_status = st;
		expected_q.push_back(r);
	endfunction

	function automatic scan_status_t found_status();
		return (32'(resp_bytes) > HEADER_BYTES) ? ST_OK : ST_NOT_FOUND;
	endfunction

	task automatic predict_pairs(entry_t e);
		bit type_hit;
		bit fits;
		step_results = 0;
		if (scan_closed) begin
			open_first  = '0;
			open_last   = '0;
			resp_bytes  = 16'(HEADER_BYTES);
			scan_closed = 1'b0;
		end
		if (lo_handle == '0 || lo_handle > hi_handle) begin
			end_scan(ST_INVALID_RANGE);
			return;
		end
		if (e.entry_handle > hi_handle) begin
			void'(close_run());
			end_scan(found_status());
			return;
		end
		type_hit = (e.entry_handle >= lo_handle) && (e.entry_type16 == match_type);
		if (type_hit && e.value_read_failed) begin
			end_scan(ST_READ_FAIL);
			return;
		end
		if (type_hit && e.value_equal) begin
			if (open_first == '0) begin
				open_first = e.entry_handle;
				open_last  = e.entry_handle;
			end else if ({1'b0, e.entry_handle} == {1'b0, open_last} + 17'd1) begin
				open_last = e.entry_handle;
			end else begin
				fits = close_run();
				open_first = e.entry_handle;
				open_last  = e.entry_handle;
				if (!fits) begin
					end_scan(found_status());
					return;
				end
			end
		end else if (!close_run()) begin
			end_scan(found_status());
			return;
		end
		if (e.last_entry) begin
			void'(close_run());
			end_scan(found_status());
		end
	endtask

	function automatic void check_field(string field, int unsigned want, int unsigned seen);
		if (want != seen) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, seen);
			errors++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		entry_t  e;
		result_t want;
		if (!arst_n) begin
			lo_handle   = RANGE_START_RST;
			hi_handle   = RANGE_END_RST;
			match_type  = WANTED_TYPE_RST;
			mtu_bytes   = MTU_RST;
			open_first  = '0;
			open_last   = '0;
			resp_bytes  = 16'(HEADER_BYTES);
			scan_closed = 1'b0;
			expected_q.delete();
			errors = 0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				if (expected_q.size() == 0) begin
					$display("%0t: result transfer with nothing expected, actual %0b %0h %0h %0b %0d",
						$time, result_ch.range_valid, result_ch.group_start, result_ch.group_end,
						result_ch.scan_done, result_ch.scan_status);
					errors++;
				end else begin
					want = expected_q.pop_front();
					check_field("range_valid", want.range_valid, result_ch.range_valid);
					check_field("group_start", want.group_start, result_ch.group_start);
					check_field("group_end", want.group_end, result_ch.group_end);
					check_field("scan_done", want.scan_done, result_ch.scan_done);
					check_field("scan_status", want.scan_status, result_ch.scan_status);
				end
			end
			if (cfg_ch.valid && cfg_ch.ready) begin
				case (cfg_reg_t'(cfg_ch.index))
					REG_RANGE_START: lo_handle  = cfg_ch.data;
					REG_RANGE_END:   hi_handle  = cfg_ch.data;
					REG_WANTED_TYPE: match_type = cfg_ch.data;
					REG_CHANNEL_MTU: mtu_bytes  = cfg_ch.data;
					default: ;
				endcase
			end
			if (entry_ch.valid && entry_ch.ready) begin
				e.entry_handle      = entry_ch.entry_handle;
				e.entry_type16      = entry_ch.entry_type16;
				e.value_equal       = entry_ch.value_equal;
				e.value_read_failed = entry_ch.value_read_failed;
				e.last_entry        = entry_ch.last_entry;
				predict_pairs(e);
			end
		end
		fail_count    <= errors;
		pending_count <= expected_q.size();
	end

endmodule

// ===== tb/testbench.sv =====
// Top of the handle range coalescer testbench: clock, reset, entry and configuration
// stimulus, result back-pressure and the verdict.
// Depends on hrc_pkg, hrc_ifs, handle_range_coalescer and hrc_checker.
module testbench;
	import hrc_pkg::*;

	localparam int RESET_CYCLES = 11;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_ITEMS = 650;
	localparam int DRAIN_CYCLES = 6;
	localparam int HOLD_CYCLES  = 200;

	logic clk;
	logic arst_n;
	int   cycle_count = 0;
	int   fail_count;
	int   pending_count;
	bit   steady;
	bit   hold_req;

	logic [HANDLE_W-1:0] cfg_lo, cfg_hi, cfg_type, cfg_mtu;

	hrc_entry_if  entry_ch();
	hrc_cfg_if    cfg_ch();
	hrc_result_if result_ch();

	handle_range_coalescer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.entry_ch  (entry_ch),
		.cfg_ch    (cfg_ch),
		.result_ch (result_ch)
	);

	hrc_checker pair_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.entry_ch      (entry_ch),
		.cfg_ch        (cfg_ch),
		.result_ch     (result_ch),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic int idle_len();
		int pick;
		if (steady) return 0;
		pick = $urandom_range(0, 99);
		if (pick < 55) return 0;
		if (pick < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic entry_t entry_of(int h, int t, bit eq, bit fail, bit last);
		entry_t e;
		e.entry_handle      = 16'(h);
		e.entry_type16      = 16'(t);
		e.value_equal       = eq;
		e.value_read_failed = fail;
		e.last_entry        = last;
		return e;
	endfunction

	// Returns at the edge of the transfer with valid still high.
	task automatic send_entry(entry_t e);
		int gap;
		gap = idle_len();
		if (gap > 0) begin
			entry_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		entry_ch.valid             <= 1'b1;
		entry_ch.entry_handle      <= e.entry_handle;
		entry_ch.entry_type16      <= e.entry_type16;
		entry_ch.value_equal       <= e.value_equal;
		entry_ch.value_read_failed <= e.value_read_failed;
		entry_ch.last_entry        <= e.last_entry;
		@(posedge clk);
		while (!entry_ch.ready) @(posedge clk);
	endtask

	task automatic drain();
		entry_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [HANDLE_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		case (idx)
			REG_RANGE_START: cfg_lo   = value;
			REG_RANGE_END:   cfg_hi   = value;
			REG_WANTED_TYPE: cfg_type = value;
			REG_CHANNEL_MTU: cfg_mtu  = value;
			default: ;
		endcase
	endtask

	task automatic apply_config(logic [HANDLE_W-1:0] lo, logic [HANDLE_W-1:0] hi,
		logic [HANDLE_W-1:0] typ, logic [HANDLE_W-1:0] mtu);
		write_reg(REG_RANGE_START, lo);
		write_reg(REG_RANGE_END, hi);
		write_reg(REG_WANTED_TYPE, typ);
		write_reg(REG_CHANNEL_MTU, mtu);
		cfg_ch.valid <= 1'b0;
	endtask

	// One ascending scan, ending on a last entry or a handle past the range.
	task automatic run_scan(input int max_len, inout int sent);
		entry_t e;
		int     h;
		int     len;
		int     pick;
		int     step;
		bit     stop;
		len  = $urandom_range(1, max_len);
		pick = $urandom_range(0, 9);
		if (pick < 6) h = int'(cfg_lo) - $urandom_range(0, 6);
		else if (pick < 8) h = $urandom_range(1, 65535);
		else h = 65535 - $urandom_range(0, len + 2);
		if (h < 1) h = 1;
		stop = 1'b0;
		for (int i = 0; i < len && !stop; i++) begin
			e = '0;
			e.entry_handle = 16'(h);
			pick = $urandom_range(0, 99);
			if (pick < 80) e.entry_type16 = cfg_type;
			else if (pick < 92) e.entry_type16 = 16'($urandom);
			else e.entry_type16 = '0;
			e.value_equal = ($urandom_range(0, 99) < 85);
			e.value_read_failed = ($urandom_range(0, 99) <
				((e.entry_type16 == cfg_type) ? 3 : 15));
			if (i == len - 1) begin
				if ($urandom_range(0, 1) == 1 && cfg_hi < 16'hFFE0) begin
					e.entry_handle = cfg_hi + 16'($urandom_range(1, 20));
					e.last_entry   = 1'($urandom_range(0, 1));
				end else begin
					e.last_entry = 1'b1;
				end
			end
			pick = $urandom_range(0, 9);
			step = (pick < 7) ? 1 : (pick < 9) ? $urandom_range(2, 4) : $urandom_range(5, 60);
			h += step;
			if (h > 65535) begin
				e.last_entry = 1'b1;
				stop = 1'b1;
			end
			send_entry(e);
			sent++;
		end
	endtask

	// Result side: ready bursts, random stalls and one long hold-off on request.
	initial begin
		int stall;
		result_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			result_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 24)) @(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				result_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				stall = idle_len();
				if (stall > 0) begin
					result_ch.ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
		end
	end

	initial begin
		entry_t              noise;
		int                  random_sent;
		int                  phase_sent;
		int                  quota;
		int                  phase;
		int                  kind;
		logic [HANDLE_W-1:0] lo, hi, typ, mtu;

		arst_n                     = 1'b0;
		steady                     = 1'b0;
		hold_req                   = 1'b0;
		entry_ch.valid             = 1'b0;
		entry_ch.entry_handle      = '0;
		entry_ch.entry_type16      = '0;
		entry_ch.value_equal       = 1'b0;
		entry_ch.value_read_failed = 1'b0;
		entry_ch.last_entry        = 1'b0;
		cfg_ch.valid               = 1'b0;
		cfg_ch.index               = REG_RANGE_START;
		cfg_ch.data                = '0;
		cfg_lo                     = RANGE_START_RST;
		cfg_hi                     = RANGE_END_RST;
		cfg_type                   = WANTED_TYPE_RST;
		cfg_mtu                    = MTU_RST;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset configuration: merge, split, type miss, read failure drops the run
		send_entry(entry_of(1, 0, 1, 0, 0));
		send_entry(entry_of(2, 0, 1, 0, 0));
		send_entry(entry_of(4, 0, 1, 0, 0));
		send_entry(entry_of(5, 16'h2800, 1, 0, 0));
		send_entry(entry_of(6, 0, 1, 0, 0));
		send_entry(entry_of(7, 0, 1, 1, 0));
		// nothing found
		send_entry(entry_of(10, 0, 0, 0, 1));
		// sixth pair does not fit the 23 byte MTU
		for (int i = 0; i < 7; i++) send_entry(entry_of(20 + 2 * i, 0, 1, 0, 0));
		// run ending at the top handle, then a lower handle with last
		send_entry(entry_of(16'hFFFE, 0, 1, 0, 0));
		send_entry(entry_of(16'hFFFF, 0, 1, 0, 0));
		send_entry(entry_of(1, 0, 1, 0, 1));
		drain();

		apply_config(16'd0, 16'hFFFF, 16'h0000, 16'd23);
		send_entry(entry_of(300, 0, 1, 0, 0));
		drain();
		apply_config(16'd200, 16'd100, 16'h0000, 16'd23);
		send_entry(entry_of(150, 0, 1, 0, 0));
		drain();

		apply_config(16'd100, 16'd200, 16'hABCD, 16'hFFFF);
		send_entry(entry_of(50, 16'hABCD, 1, 1, 0));
		send_entry(entry_of(100, 16'hABCD, 1, 0, 0));
		send_entry(entry_of(101, 16'hABCD, 1, 0, 0));
		send_entry(entry_of(201, 16'hABCD, 1, 0, 0));
		send_entry(entry_of(202, 16'hFFFF, 0, 0, 0));
		send_entry(entry_of(150, 16'h1234, 1, 1, 1));
		drain();

		apply_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd23);
		send_entry(entry_of(16'hFFFF, 16'hFFFF, 1, 0, 1));

		random_sent = 0;
		phase = 0;
		while (random_sent < RANDOM_ITEMS) begin
			drain();
			kind = (phase < 6) ? phase : $urandom_range(0, 5);
			quota = $urandom_range(60, 110);
			typ = 16'($urandom);
			case (kind)
				0: begin
					lo  = 16'($urandom_range(1, 300));
					hi  = lo + 16'($urandom_range(20, 2000));
					mtu = 16'($urandom_range(23, 40));
				end
				1: begin
					lo    = 16'd1;
					hi    = 16'hFFFF;
					mtu   = 16'hFFFF;
					quota = 120;
				end
				2: begin
					if ($urandom_range(0, 1) == 1) begin
						lo = 16'd0;
						hi = 16'($urandom);
					end else begin
						lo = 16'($urandom_range(1000, 65535));
						hi = lo - 16'($urandom_range(1, 999));
					end
					mtu   = 16'($urandom_range(23, 65535));
					quota = 12;
				end
				3: begin
					lo    = 16'hFFFF;
					hi    = 16'hFFFF;
					mtu   = 16'd23;
					quota = 15;
				end
				4: begin
					lo  = 16'($urandom_range(1, 60000));
					hi  = lo + 16'($urandom_range(0, 500));
					mtu = 16'($urandom_range(23, 200));
				end
				default: begin
					lo  = 16'($urandom);
					hi  = 16'($urandom);
					mtu = 16'($urandom_range(23, 65535));
				end
			endcase
			apply_config(lo, hi, typ, mtu);
			steady = (phase == 1);
			if (phase == 1) hold_req = 1'b1;
			phase_sent = 0;
			while (phase_sent < quota) begin
				if ($urandom_range(0, 9) == 0) begin
					noise.entry_handle      = 16'($urandom_range(1, 65535));
					noise.entry_type16      = 16'($urandom);
					noise.value_equal       = 1'($urandom);
					noise.value_read_failed = 1'($urandom);
					noise.last_entry        = 1'($urandom);
					send_entry(noise);
					phase_sent++;
				end else begin
					run_scan(24, phase_sent);
				end
			end
			random_sent += phase_sent;
			phase++;
		end
		steady = 1'b0;
		drain();

		if (fail_count == 0 && pending_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== handle_range_coalescer.f =====
hdl/hrc_pkg.sv
hdl/hrc_ifs.sv
hdl/hrc_outq.sv
hdl/hrc_scan.sv
hdl/handle_range_coalescer.sv
tb/hrc_checker.sv
tb/testbench.sv
